// ----- rtl/core/nac_pkg.sv -----
// shared types and constants for the neighbour address cache
`timescale 1ns / 1ps
`default_nettype none

package nac_pkg;

   localparam int IP_W  = 64;
   localparam int KEY_W = 2 * IP_W;
   localparam int MAC_W = 48;
   localparam int STATUS_W = 2;

   localparam logic MODE_INSERT = 1'b0;
   localparam logic MODE_LOOKUP = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_RESULT
   } state_type;

endpackage

`default_nettype wire

// ----- rtl/core/nac_key_store.sv -----
// key memory with registered read port and address comparator
`timescale 1ns / 1ps
`default_nettype none

module nac_key_store
   import nac_pkg::*;
#(
   parameter int ENTRIES = 16
) (
   input  wire logic                                     clock,
   input  wire logic                                     rd_en,
   input  wire logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] rd_addr,
   input  wire logic                                     wr_en,
   input  wire logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] wr_addr,
   input  wire logic [KEY_W-1:0]                         wr_key,
   input  wire logic [KEY_W-1:0]                         cmp_key,
   output      logic                                     key_match
);

   logic [KEY_W-1:0] key_mem [ENTRIES];
   logic [KEY_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem[wr_addr] <= wr_key;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= key_mem[rd_addr];
      end
   end

   assign key_match = (rd_data_ff == cmp_key);

endmodule

`default_nettype wire

// ----- rtl/core/neighbor_address_cache.sv -----
// neighbour address cache: ipv6 to mac table with sequential associative scan
// a request scans the key memory one entry after another, reading one key per entry,
//   and the scan stops early when a match is found; a miss walks all ENTRIES entries
// req_stall holds off new requests until the response enters the output register
// a finished response waits in the output register while the next request is taken
// reset clears all valid flags at once; key and mac memories hold no reset value
`timescale 1ns / 1ps
`default_nettype none

module neighbor_address_cache
   import nac_pkg::*;
#(
   parameter int ENTRIES = 16
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output      logic                req_stall,
   input  wire logic                req_mode,
   input  wire logic [IP_W-1:0]     req_ip_high,
   input  wire logic [IP_W-1:0]     req_ip_low,
   input  wire logic [MAC_W-1:0]    req_new_mac,
   output      logic                rsp_valid,
   input  wire logic                rsp_stall,
   output      logic [STATUS_W-1:0] rsp_status,
   output      logic [MAC_W-1:0]    rsp_found_mac
);

   localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CW = $clog2(ENTRIES + 1);
   localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);
   localparam logic [CW-1:0] COUNT_END = CW'(ENTRIES);

   state_type state_ff, state_in;

   logic                mode_ff;
   logic [KEY_W-1:0]    key_ff;
   logic [MAC_W-1:0]    mac_ff;
   logic [CW-1:0]       rd_cnt_ff;
   logic                cmp_live_ff;
   logic [IW-1:0]       cmp_idx_ff;
   logic                free_found_ff;
   logic [IW-1:0]       free_idx_ff;
   logic [ENTRIES-1:0]  valid_ff;
   logic [STATUS_W-1:0] res_status_ff, res_status_in;
   logic                res_use_mem_ff, res_use_mem_in;
   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [MAC_W-1:0]    rsp_mac_ff;
   logic [MAC_W-1:0]    mac_mem [ENTRIES];
   logic [MAC_W-1:0]    mac_rd_ff;

   logic          req_take;
   logic          rd_go;
   logic          key_match;
   logic          valid_rd;
   logic          hit_now;
   logic          free_any;
   logic [IW-1:0] free_sel;
   logic          key_wr_en;
   logic          mac_wr_en;
   logic [IW-1:0] wr_addr;
   logic          mac_rd_en;
   logic          rsp_load;

   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign rd_go     = (state_ff == S_SCAN) && (rd_cnt_ff < COUNT_END);
   assign valid_rd  = valid_ff[cmp_idx_ff];
   assign hit_now   = cmp_live_ff && valid_rd && key_match;
   assign free_any  = free_found_ff || !valid_rd;
   assign free_sel  = free_found_ff ? free_idx_ff : cmp_idx_ff;

   nac_key_store #(
      .ENTRIES(ENTRIES)
   ) u_key_store (
      .clock    (clock),
      .rd_en    (rd_go),
      .rd_addr  (rd_cnt_ff[IW-1:0]),
      .wr_en    (key_wr_en),
      .wr_addr  (wr_addr),
      .wr_key   (key_ff),
      .cmp_key  (key_ff),
      .key_match(key_match)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      key_wr_en      = 1'b0;
      mac_wr_en      = 1'b0;
      wr_addr        = cmp_idx_ff;
      mac_rd_en      = 1'b0;
      rsp_load       = 1'b0;
      res_status_in  = res_status_ff;
      res_use_mem_in = res_use_mem_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (cmp_live_ff && (hit_now || (cmp_idx_ff == LAST))) begin
               state_in       = S_RESULT;
               res_use_mem_in = 1'b0;
               if (mode_ff == MODE_LOOKUP) begin
                  if (hit_now) begin
                     mac_rd_en      = 1'b1;
                     res_status_in  = STATUS_OK;
                     res_use_mem_in = 1'b1;
                  end else begin
                     res_status_in = STATUS_NOT_FOUND;
                  end
               end else begin
                  if (hit_now) begin
                     mac_wr_en     = 1'b1;
                     res_status_in = STATUS_OK;
                  end else if (free_any) begin
                     key_wr_en     = 1'b1;
                     mac_wr_en     = 1'b1;
                     wr_addr       = free_sel;
                     res_status_in = STATUS_OK;
                  end else begin
                     res_status_in = STATUS_FULL;
                  end
               end
            end
         end
         S_RESULT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         mode_ff <= req_mode;
         key_ff  <= {req_ip_high, req_ip_low};
         mac_ff  <= req_new_mac;
      end
      res_status_ff  <= res_status_in;
      res_use_mem_ff <= res_use_mem_in;
      cmp_idx_ff     <= rd_cnt_ff[IW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_cnt_ff     <= '0;
         cmp_live_ff   <= 1'b0;
         free_found_ff <= 1'b0;
         free_idx_ff   <= '0;
      end else begin
         cmp_live_ff <= rd_go;
         if (req_take) begin
            rd_cnt_ff     <= '0;
            free_found_ff <= 1'b0;
         end else begin
            if (rd_go) begin
               rd_cnt_ff <= rd_cnt_ff + CW'(1);
            end
            if ((state_ff == S_SCAN) && cmp_live_ff && !valid_rd && !free_found_ff) begin
               free_found_ff <= 1'b1;
               free_idx_ff   <= cmp_idx_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (key_wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mac_wr_en) begin
         mac_mem[wr_addr] <= mac_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mac_rd_en) begin
         mac_rd_ff <= mac_mem[cmp_idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_mac_ff    <= res_use_mem_ff ? mac_rd_ff : '0;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_found_mac = rsp_mac_ff;

endmodule

`default_nettype wire
